// File: rtl/core/pn3d_pkg.sv
// Package for the 3D gradient noise evaluator: formats, register indices and tables.
package pn3d_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int OUT_FRAC_BITS_DEF = 16;
	localparam int COORD_W           = 32;
	localparam int OUT_W             = 18;
	localparam int PERIOD_W          = 9;
	localparam int SEED_W            = 8;
	localparam int CFG_IDX_W         = 2;

	localparam logic [CFG_IDX_W-1:0] REG_X_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd3;

	localparam logic [7:0] PERM_TAB [256] = '{
		8'd23,8'd125,8'd161,8'd52,8'd103,8'd117,8'd70,8'd37,
		8'd247,8'd101,8'd203,8'd169,8'd124,8'd126,8'd44,8'd123,
		8'd152,8'd238,8'd145,8'd45,8'd171,8'd114,8'd253,8'd10,
		8'd192,8'd136,8'd4,8'd157,8'd249,8'd30,8'd35,8'd72,
		8'd175,8'd63,8'd77,8'd90,8'd181,8'd16,8'd96,8'd111,
		8'd133,8'd104,8'd75,8'd162,8'd93,8'd56,8'd66,8'd240,
		8'd8,8'd50,8'd84,8'd229,8'd49,8'd210,8'd173,8'd239,
		8'd141,8'd1,8'd87,8'd18,8'd2,8'd198,8'd143,8'd57,
		8'd225,8'd160,8'd58,8'd217,8'd168,8'd206,8'd245,8'd204,
		8'd199,8'd6,8'd73,8'd60,8'd20,8'd230,8'd211,8'd233,
		8'd94,8'd200,8'd88,8'd9,8'd74,8'd155,8'd33,8'd15,
		8'd219,8'd130,8'd226,8'd202,8'd83,8'd236,8'd42,8'd172,
		8'd165,8'd218,8'd55,8'd222,8'd46,8'd107,8'd98,8'd154,
		8'd109,8'd67,8'd196,8'd178,8'd127,8'd158,8'd13,8'd243,
		8'd65,8'd79,8'd166,8'd248,8'd25,8'd224,8'd115,8'd80,
		8'd68,8'd51,8'd184,8'd128,8'd232,8'd208,8'd151,8'd122,
		8'd26,8'd212,8'd105,8'd43,8'd179,8'd213,8'd235,8'd148,
		8'd146,8'd89,8'd14,8'd195,8'd28,8'd78,8'd112,8'd76,
		8'd250,8'd47,8'd24,8'd251,8'd140,8'd108,8'd186,8'd190,
		8'd228,8'd170,8'd183,8'd139,8'd39,8'd188,8'd244,8'd246,
		8'd132,8'd48,8'd119,8'd144,8'd180,8'd138,8'd134,8'd193,
		8'd82,8'd182,8'd120,8'd121,8'd86,8'd220,8'd209,8'd3,
		8'd91,8'd241,8'd149,8'd85,8'd205,8'd150,8'd113,8'd216,
		8'd31,8'd100,8'd41,8'd164,8'd177,8'd214,8'd153,8'd231,
		8'd38,8'd71,8'd185,8'd174,8'd97,8'd201,8'd29,8'd95,
		8'd7,8'd92,8'd54,8'd254,8'd191,8'd118,8'd34,8'd221,
		8'd131,8'd11,8'd163,8'd99,8'd234,8'd81,8'd227,8'd147,
		8'd156,8'd176,8'd17,8'd142,8'd69,8'd12,8'd110,8'd62,
		8'd27,8'd255,8'd0,8'd194,8'd59,8'd116,8'd242,8'd252,
		8'd19,8'd21,8'd187,8'd53,8'd207,8'd129,8'd64,8'd135,
		8'd61,8'd40,8'd167,8'd237,8'd102,8'd223,8'd106,8'd159,
		8'd197,8'd189,8'd215,8'd137,8'd36,8'd32,8'd22,8'd5
	};

	localparam logic [3:0] GSEL_TAB [256] = '{
		4'd7,4'd9,4'd5,4'd0,4'd11,4'd1,4'd6,4'd9,4'd3,4'd9,4'd11,4'd1,4'd8,4'd10,4'd4,4'd7,
		4'd8,4'd6,4'd1,4'd5,4'd3,4'd10,4'd9,4'd10,4'd0,4'd8,4'd4,4'd1,4'd5,4'd2,4'd7,4'd8,
		4'd7,4'd11,4'd9,4'd10,4'd1,4'd0,4'd4,4'd7,4'd5,4'd0,4'd11,4'd6,4'd1,4'd4,4'd2,4'd8,
		4'd8,4'd10,4'd4,4'd9,4'd9,4'd2,4'd5,4'd7,4'd9,4'd1,4'd7,4'd2,4'd2,4'd6,4'd11,4'd5,
		4'd5,4'd4,4'd6,4'd9,4'd0,4'd1,4'd1,4'd0,4'd7,4'd6,4'd9,4'd8,4'd4,4'd10,4'd3,4'd1,
		4'd2,4'd8,4'd8,4'd9,4'd10,4'd11,4'd5,4'd11,4'd11,4'd2,4'd6,4'd10,4'd3,4'd4,4'd2,4'd4,
		4'd9,4'd10,4'd3,4'd2,4'd6,4'd3,4'd6,4'd10,4'd5,4'd3,4'd4,4'd10,4'd11,4'd2,4'd9,4'd11,
		4'd1,4'd11,4'd10,4'd4,4'd9,4'd4,4'd11,4'd0,4'd4,4'd11,4'd4,4'd0,4'd0,4'd0,4'd7,4'd6,
		4'd10,4'd4,4'd1,4'd3,4'd11,4'd5,4'd3,4'd4,4'd2,4'd9,4'd1,4'd3,4'd0,4'd1,4'd8,4'd0,
		4'd6,4'd7,4'd8,4'd7,4'd0,4'd4,4'd6,4'd10,4'd8,4'd2,4'd3,4'd11,4'd11,4'd8,4'd0,4'd2,
		4'd4,4'd8,4'd3,4'd0,4'd0,4'd10,4'd6,4'd1,4'd2,4'd2,4'd4,4'd5,4'd6,4'd0,4'd1,4'd3,
		4'd11,4'd9,4'd5,4'd5,4'd9,4'd6,4'd9,4'd8,4'd3,4'd8,4'd1,4'd8,4'd9,4'd6,4'd9,4'd11,
		4'd10,4'd7,4'd5,4'd6,4'd5,4'd9,4'd1,4'd3,4'd7,4'd0,4'd2,4'd10,4'd11,4'd2,4'd6,4'd1,
		4'd3,4'd11,4'd7,4'd7,4'd2,4'd1,4'd7,4'd3,4'd0,4'd8,4'd1,4'd1,4'd5,4'd0,4'd6,4'd10,
		4'd11,4'd11,4'd0,4'd2,4'd7,4'd0,4'd10,4'd8,4'd3,4'd5,4'd7,4'd1,4'd11,4'd1,4'd0,4'd7,
		4'd9,4'd0,4'd11,4'd5,4'd10,4'd3,4'd2,4'd3,4'd5,4'd9,4'd7,4'd9,4'd8,4'd4,4'd6,4'd5
	};

endpackage

// File: rtl/core/perlin_noise_3d_eval.sv
// Top level of the 3D gradient noise evaluator: fully pipelined, one point per clock.
//
// Usage: drive x_coord, y_coord and z_coord with start high; a beat is taken
// whenever start is high and busy is low. busy is held low, so a new point can
// enter on every clock. Each point yields one noise_value beat, flagged by
// done for exactly one cycle. Throughput is one point per cycle through the
// ten-stage pipeline:
// floor and fade products, two fade stages, three permutation lookups,
// gradient dots, three blend stages, output scaling and saturation.
// The receiver cannot stall; results are simply presented on done.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and is meant to be written while no point is in flight.
// Reset (arst_n low) clears all valid bits and registers to zero periods
// (wrap 256) and a zero seed; points in flight are dropped.
module perlin_noise_3d_eval #(
	parameter int FRAC_BITS     = pn3d_pkg::FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = pn3d_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [pn3d_pkg::COORD_W-1:0]   x_coord,
	input  logic signed [pn3d_pkg::COORD_W-1:0]   y_coord,
	input  logic signed [pn3d_pkg::COORD_W-1:0]   z_coord,
	output logic                                  done,
	output logic signed [pn3d_pkg::OUT_W-1:0]     noise_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pn3d_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pn3d_pkg::PERIOD_W-1:0]         cfg_data
);
	import pn3d_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int IW  = COORD_W - F;
	localparam int NW  = F + 4;
	localparam int DEPTH = 10;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	typedef logic [F-1:0] frac_t;
	typedef logic signed [F+1:0] off_t;
	typedef logic signed [NW-1:0] val_t;

	logic [PERIOD_W-1:0] x_period_q, y_period_q, z_period_q;
	logic [SEED_W-1:0]   seed_q;
	logic [DEPTH-1:0]    vld_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	wire acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_period_q <= '0;
			y_period_q <= '0;
			z_period_q <= '0;
			seed_q     <= '0;
			vld_q      <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], acc};
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_PERIOD: x_period_q <= cfg_data;
					REG_Y_PERIOD: y_period_q <= cfg_data;
					REG_Z_PERIOD: z_period_q <= cfg_data;
					REG_SEED:     seed_q     <= cfg_data[SEED_W-1:0];
					default:      ;
				endcase
			end
		end
	end

	function automatic val_t dot_g(input logic [3:0] g, input off_t dx, input off_t dy,
		input off_t dz);
		val_t ex, ey, ez;
		ex = NW'(dx);
		ey = NW'(dy);
		ez = NW'(dz);
		case (g)
			4'd0:    dot_g =  ex + ey;
			4'd1:    dot_g = -ex + ey;
			4'd2:    dot_g =  ex - ey;
			4'd3:    dot_g = -ex - ey;
			4'd4:    dot_g =  ex + ez;
			4'd5:    dot_g = -ex + ez;
			4'd6:    dot_g =  ex - ez;
			4'd7:    dot_g = -ex - ez;
			4'd8:    dot_g =  ey + ez;
			4'd9:    dot_g = -ey + ez;
			4'd10:   dot_g =  ey - ez;
			default: dot_g = -ey - ez;
		endcase
	endfunction

	// lerp with floor shift; product of a value and a fade in [0, ONE]
	function automatic val_t lerp(input val_t a, input val_t b, input logic [F:0] t);
		logic signed [NW+F+2:0] p;
		p = (NW+F+3)'(b - a) * $signed({1'b0, t});
		lerp = a + NW'(p >>> F);
	endfunction

	// stage 1: split, wrap, fade first products
	frac_t fx_s1, fy_s1, fz_s1;
	logic [7:0] x0_s1, x1_s1, y0_s1, y1_s1, z0_s1, z1_s1;
	logic [2*F-1:0] sqx_s1, sqy_s1, sqz_s1;
	always_ff @(posedge clk) begin
		logic [7:0] mx, my, mz;
		logic [IW-1:0] px, py, pz;
		mx = 8'(x_period_q - 9'd1);
		my = 8'(y_period_q - 9'd1);
		mz = 8'(z_period_q - 9'd1);
		px = x_coord[COORD_W-1:F];
		py = y_coord[COORD_W-1:F];
		pz = z_coord[COORD_W-1:F];
		fx_s1 <= x_coord[F-1:0];
		fy_s1 <= y_coord[F-1:0];
		fz_s1 <= z_coord[F-1:0];
		x0_s1 <= 8'(px) & mx;
		x1_s1 <= 8'(px + IW'(1)) & mx;
		y0_s1 <= 8'(py) & my;
		y1_s1 <= 8'(py + IW'(1)) & my;
		z0_s1 <= 8'(pz) & mz;
		z1_s1 <= 8'(pz + IW'(1)) & mz;
		sqx_s1 <= x_coord[F-1:0] * x_coord[F-1:0];
		sqy_s1 <= y_coord[F-1:0] * y_coord[F-1:0];
		sqz_s1 <= z_coord[F-1:0] * z_coord[F-1:0];
	end

	// stage 2: q term and cubic; first permutation lookup
	frac_t fx_s2, fy_s2, fz_s2;
	logic [7:0] y0_s2, y1_s2, z0_s2, z1_s2, r0_s2, r1_s2;
	logic [F+4:0] qx_s2, qy_s2, qz_s2;
	logic [F-1:0] cx_s2, cy_s2, cz_s2;
	always_ff @(posedge clk) begin
		fx_s2 <= fx_s1; fy_s2 <= fy_s1; fz_s2 <= fz_s1;
		y0_s2 <= y0_s1; y1_s2 <= y1_s1; z0_s2 <= z0_s1; z1_s2 <= z1_s1;
		r0_s2 <= PERM_TAB[8'(x0_s1 + seed_q)];
		r1_s2 <= PERM_TAB[8'(x1_s1 + seed_q)];
		qx_s2 <= (F+5)'((3*F+3)'(sqx_s1) * 6 >> F) + (F+5)'(10) * (F+5)'(ONE)
			- (F+5)'(15) * (F+5)'(fx_s1);
		qy_s2 <= (F+5)'((3*F+3)'(sqy_s1) * 6 >> F) + (F+5)'(10) * (F+5)'(ONE)
			- (F+5)'(15) * (F+5)'(fy_s1);
		qz_s2 <= (F+5)'((3*F+3)'(sqz_s1) * 6 >> F) + (F+5)'(10) * (F+5)'(ONE)
			- (F+5)'(15) * (F+5)'(fz_s1);
		cx_s2 <= F'(((2*F)'(sqx_s1[2*F-1:F]) * fx_s1) >> F);
		cy_s2 <= F'(((2*F)'(sqy_s1[2*F-1:F]) * fy_s1) >> F);
		cz_s2 <= F'(((2*F)'(sqz_s1[2*F-1:F]) * fz_s1) >> F);
	end

	// stage 3: fade result; second lookup
	frac_t fx_s3, fy_s3, fz_s3;
	logic [7:0] z0_s3, z1_s3, r00_s3, r01_s3, r10_s3, r11_s3;
	logic [F:0] u_s3, v_s3, w_s3;
	always_ff @(posedge clk) begin
		fx_s3 <= fx_s2; fy_s3 <= fy_s2; fz_s3 <= fz_s2;
		z0_s3 <= z0_s2; z1_s3 <= z1_s2;
		r00_s3 <= PERM_TAB[8'(r0_s2 + y0_s2)];
		r01_s3 <= PERM_TAB[8'(r0_s2 + y1_s2)];
		r10_s3 <= PERM_TAB[8'(r1_s2 + y0_s2)];
		r11_s3 <= PERM_TAB[8'(r1_s2 + y1_s2)];
		u_s3 <= (F+1)'(((2*F+5)'(cx_s2) * qx_s2) >> F);
		v_s3 <= (F+1)'(((2*F+5)'(cy_s2) * qy_s2) >> F);
		w_s3 <= (F+1)'(((2*F+5)'(cz_s2) * qz_s2) >> F);
	end

	// stage 4: gradient selects
	frac_t fx_s4, fy_s4, fz_s4;
	logic [F:0] u_s4, v_s4, w_s4;
	logic [3:0] g_s4 [8];
	always_ff @(posedge clk) begin
		logic [7:0] rr [4];
		fx_s4 <= fx_s3; fy_s4 <= fy_s3; fz_s4 <= fz_s3;
		u_s4 <= u_s3; v_s4 <= v_s3; w_s4 <= w_s3;
		rr[0] = r00_s3; rr[1] = r01_s3; rr[2] = r10_s3; rr[3] = r11_s3;
		for (int i = 0; i < 4; i++) begin
			g_s4[2*i]   <= GSEL_TAB[8'(rr[i] + z0_s3)];
			g_s4[2*i+1] <= GSEL_TAB[8'(rr[i] + z1_s3)];
		end
	end

	// stage 5: corner dots
	logic [F:0] u_s5, v_s5, w_s5;
	val_t d_s5 [8];
	always_ff @(posedge clk) begin
		off_t ox [2], oy [2], oz [2];
		ox[0] = off_t'({2'b00, fx_s4}); ox[1] = ox[0] - off_t'(ONE);
		oy[0] = off_t'({2'b00, fy_s4}); oy[1] = oy[0] - off_t'(ONE);
		oz[0] = off_t'({2'b00, fz_s4}); oz[1] = oz[0] - off_t'(ONE);
		u_s5 <= u_s4; v_s5 <= v_s4; w_s5 <= w_s4;
		for (int i = 0; i < 8; i++)
			d_s5[i] <= dot_g(g_s4[i], ox[i>>2], oy[(i>>1)&1], oz[i&1]);
	end

	// stage 6..8: blends along z, y, x
	logic [F:0] u_s6, v_s6, u_s7;
	val_t n_s6 [4];
	val_t n_s7 [2];
	val_t r_s8;
	always_ff @(posedge clk) begin
		u_s6 <= u_s5; v_s6 <= v_s5; u_s7 <= u_s6;
		for (int i = 0; i < 4; i++)
			n_s6[i] <= lerp(d_s5[2*i], d_s5[2*i+1], w_s5);
		n_s7[0] <= lerp(n_s6[0], n_s6[1], v_s6);
		n_s7[1] <= lerp(n_s6[2], n_s6[3], v_s6);
		r_s8 <= lerp(n_s7[0], n_s7[1], u_s7);
	end

	// stage 9: rescale; stage 10: saturate
	localparam int SW = NW + 26;
	logic signed [SW-1:0] s_s9;
	logic signed [OUT_W-1:0] o_s10;
	always_ff @(posedge clk) begin
		if (OUT_FRAC_BITS >= F)
			s_s9 <= SW'(r_s8) <<< (OUT_FRAC_BITS - F);
		else
			s_s9 <= SW'(r_s8) >>> (F - OUT_FRAC_BITS);
		if (s_s9 > SW'(131071))
			o_s10 <= OUT_W'(131071);
		else if (s_s9 < -SW'(131072))
			o_s10 <= OUT_W'(-131072);
		else
			o_s10 <= OUT_W'(s_s9);
	end

	assign done = vld_q[DEPTH-1];
	assign noise_value = o_s10;

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##DEPTH done)
		else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, DEPTH))
		else $error("result without item");

endmodule

// File: test/perlin_noise_3d_eval_chk.sv
// Checker for the noise evaluator: mirrors the configuration, predicts each sample and compares.
`timescale 1ns / 1ps
module perlin_noise_3d_eval_chk
	import pn3d_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic signed [COORD_W-1:0]   x_coord,
	input  logic signed [COORD_W-1:0]   y_coord,
	input  logic signed [COORD_W-1:0]   z_coord,
	input  logic                        done,
	input  logic signed [OUT_W-1:0]     noise_value,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [PERIOD_W-1:0]         cfg_data,
	output int                          fail_count,
	output int                          pending
);

	localparam int FB = FRAC_BITS_DEF;
	localparam int OB = OUT_FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) <<< FB;
	localparam int EDGE_X [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
	localparam int EDGE_Y [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
	localparam int EDGE_Z [12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

	logic [PERIOD_W-1:0] per_x, per_y, per_z;
	logic [SEED_W-1:0]   seed;
	logic signed [OUT_W-1:0] noise_q [$];

	assign pending = noise_q.size();

	function automatic longint fade_q(longint f);
		longint q, c;
		q = ((6 * f * f) >>> FB) + 10 * ONE - 15 * f;
		c = (((f * f) >>> FB) * f) >>> FB;
		return (c * q) >>> FB;
	endfunction

	function automatic longint mix(longint a, longint b, longint t);
		return a + (((b - a) * t) >>> FB);
	endfunction

	function automatic longint grad_dot(int unsigned h, longint dx, longint dy, longint dz);
		int sel;
		sel = GSEL_TAB[h & 255] % 12;
		return EDGE_X[sel] * dx + EDGE_Y[sel] * dy + EDGE_Z[sel] * dz;
	endfunction

	function automatic int unsigned wrap_mask(logic [PERIOD_W-1:0] p);
		return (int'(p) - 1) & 255;
	endfunction

	function automatic logic signed [OUT_W-1:0] noise_at(longint cx, longint cy, longint cz);
		longint px, py, pz, fx, fy, fz, gx, gy, gz, u, v, w;
		longint n00, n01, n10, n11, n0, n1, r;
		int unsigned mx, my, mz, x0, x1, y0, y1, z0, z1;
		int unsigned r0, r1, r00, r01, r10, r11;
		px = cx >>> FB; py = cy >>> FB; pz = cz >>> FB;
		fx = cx & (ONE - 1); fy = cy & (ONE - 1); fz = cz & (ONE - 1);
		mx = wrap_mask(per_x); my = wrap_mask(per_y); mz = wrap_mask(per_z);
		x0 = px & mx; x1 = (px + 1) & mx;
		y0 = py & my; y1 = (py + 1) & my;
		z0 = pz & mz; z1 = (pz + 1) & mz;
		u = fade_q(fx); v = fade_q(fy); w = fade_q(fz);
		gx = fx - ONE; gy = fy - ONE; gz = fz - ONE;
		r0 = PERM_TAB[(x0 + seed) & 255];
		r1 = PERM_TAB[(x1 + seed) & 255];
		r00 = PERM_TAB[(r0 + y0) & 255];
		r01 = PERM_TAB[(r0 + y1) & 255];
		r10 = PERM_TAB[(r1 + y0) & 255];
		r11 = PERM_TAB[(r1 + y1) & 255];
		n00 = mix(grad_dot(r00 + z0, fx, fy, fz), grad_dot(r00 + z1, fx, fy, gz), w);
		n01 = mix(grad_dot(r01 + z0, fx, gy, fz), grad_dot(r01 + z1, fx, gy, gz), w);
		n10 = mix(grad_dot(r10 + z0, gx, fy, fz), grad_dot(r10 + z1, gx, fy, gz), w);
		n11 = mix(grad_dot(r11 + z0, gx, gy, fz), grad_dot(r11 + z1, gx, gy, gz), w);
		n0 = mix(n00, n01, v);
		n1 = mix(n10, n11, v);
		r = mix(n0, n1, u);
		if (OB >= FB)
			r = r <<< (OB - FB);
		else
			r = r >>> (FB - OB);
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r[OUT_W-1:0];
	endfunction

	task automatic report(string what, longint want, longint got);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_x <= '0; per_y <= '0; per_z <= '0; seed <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_PERIOD: per_x <= cfg_data;
				REG_Y_PERIOD: per_y <= cfg_data;
				REG_Z_PERIOD: per_z <= cfg_data;
				REG_SEED:     seed  <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n) begin
			if (done) begin
				if (noise_q.size() == 0)
					report("unexpected beat, noise_value", 0, noise_value);
				else begin
					want = noise_q.pop_front();
					if (noise_value !== want)
						report("noise_value", want, noise_value);
				end
			end
			if (start && !busy)
				noise_q.push_back(noise_at(x_coord, y_coord, z_coord));
		end
	end

endmodule

// File: test/perlin_noise_3d_eval_tb.sv
// Testbench top for the noise evaluator: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module perlin_noise_3d_eval_tb;
	import pn3d_pkg::*;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	logic signed [COORD_W-1:0] x_coord, y_coord, z_coord;
	logic signed [OUT_W-1:0]   noise_value;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [PERIOD_W-1:0]       cfg_data;
	int fail_count, pending, idle_pct;

	perlin_noise_3d_eval dut (.*);
	perlin_noise_3d_eval_chk chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (14) @(posedge clk);
	endtask

	task automatic configure(int px, int py, int pz, int sd);
		drain();
		write_reg(REG_X_PERIOD, PERIOD_W'(px));
		write_reg(REG_Y_PERIOD, PERIOD_W'(py));
		write_reg(REG_Z_PERIOD, PERIOD_W'(pz));
		write_reg(REG_SEED, PERIOD_W'(sd));
		cfg_valid <= 1'b0;
	endtask

	// one beat; idle cycles after it at the phase rate
	task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		start   <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		z_coord <= z;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(3) == 0) return $urandom;
		return $signed($urandom_range(2 * 40 * 65536)) - 40 * 65536;
	endfunction

	initial begin
		logic [31:0] dir [12];
		int pct [4];
		arst_n = 0; start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		x_coord = '0; y_coord = '0; z_coord = '0; idle_pct = 0;
		dir = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0000FFFF,
			32'h00010000, 32'hFFFF0000, 32'h00008000, 32'h7FFF8000, 32'h80007FFF,
			32'h00FF0001, 32'hFF00FFFF};
		pct = '{0, 47, 0, 32};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default wrap of 256, zero seed
		for (int i = 0; i < 12; i++)
			send(dir[i], dir[(i + 5) % 12], dir[(i + 9) % 12]);
		configure(1, 2, 256, 255);
		for (int i = 0; i < 6; i++)
			send(dir[i], dir[i], dir[(i + 3) % 12]);
		// irregular masks and periods above 256
		configure(255, 300, 511, 1);
		for (int i = 0; i < 6; i++)
			send(dir[i + 6], dir[i], 32'h00050000 + i * 32'h1234);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: configure(16, 8, 4, $urandom_range(255));
				1: configure($urandom_range(511), $urandom_range(511),
					$urandom_range(511), $urandom_range(511));
				2: configure(0, 256, 32, 255);
				default: configure(2, 64, 128, 0);
			endcase
			idle_pct = pct[ph];
			for (int i = 0; i < 100; i++) begin
				send(rand_coord(), rand_coord(), rand_coord());
				if (i == 50) drain();
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/pn3d_pkg.sv
rtl/core/perlin_noise_3d_eval.sv
test/perlin_noise_3d_eval_chk.sv
test/perlin_noise_3d_eval_tb.sv
